[rtl/l4b5b_pkg.sv]
package l4b5b_pkg;

   localparam int unsigned GROUP_BITS = 5;
   localparam int unsigned PAIR_BITS  = 2 * GROUP_BITS;
   localparam int unsigned BYTE_BITS  = 8;
   localparam int unsigned NIB_BITS   = 4;

   // Two code groups pulled from the gearbox, low group in the low bits.
   typedef struct packed {
      logic                 valid;
      logic [PAIR_BITS-1:0] bits;
   } pair_type;

endpackage

[rtl/l4b5b_group_decode.sv]
module l4b5b_group_decode (
   input  logic [l4b5b_pkg::GROUP_BITS-1:0] code,
   output logic [l4b5b_pkg::NIB_BITS-1:0]   nibble,
   output logic                             code_ok
);
   import l4b5b_pkg::*;

   localparam logic [GROUP_BITS-1:0] CODE_0 = 5'b11110;
   localparam logic [GROUP_BITS-1:0] CODE_1 = 5'b01001;
   localparam logic [GROUP_BITS-1:0] CODE_2 = 5'b10100;
   localparam logic [GROUP_BITS-1:0] CODE_3 = 5'b10101;
   localparam logic [GROUP_BITS-1:0] CODE_4 = 5'b01010;
   localparam logic [GROUP_BITS-1:0] CODE_5 = 5'b01011;
   localparam logic [GROUP_BITS-1:0] CODE_6 = 5'b01110;
   localparam logic [GROUP_BITS-1:0] CODE_7 = 5'b01111;
   localparam logic [GROUP_BITS-1:0] CODE_8 = 5'b10010;
   localparam logic [GROUP_BITS-1:0] CODE_9 = 5'b10011;
   localparam logic [GROUP_BITS-1:0] CODE_A = 5'b10110;
   localparam logic [GROUP_BITS-1:0] CODE_B = 5'b10111;
   localparam logic [GROUP_BITS-1:0] CODE_C = 5'b11010;
   localparam logic [GROUP_BITS-1:0] CODE_D = 5'b11011;
   localparam logic [GROUP_BITS-1:0] CODE_E = 5'b11100;
   localparam logic [GROUP_BITS-1:0] CODE_F = 5'b11101;

   always_comb begin
      code_ok = 1'b1;
      unique case (code)
         CODE_0:  nibble = 4'h0;
         CODE_1:  nibble = 4'h1;
         CODE_2:  nibble = 4'h2;
         CODE_3:  nibble = 4'h3;
         CODE_4:  nibble = 4'h4;
         CODE_5:  nibble = 4'h5;
         CODE_6:  nibble = 4'h6;
         CODE_7:  nibble = 4'h7;
         CODE_8:  nibble = 4'h8;
         CODE_9:  nibble = 4'h9;
         CODE_A:  nibble = 4'hA;
         CODE_B:  nibble = 4'hB;
         CODE_C:  nibble = 4'hC;
         CODE_D:  nibble = 4'hD;
         CODE_E:  nibble = 4'hE;
         CODE_F:  nibble = 4'hF;
         default: begin
            nibble  = 4'h0;
            code_ok = 1'b0;
         end
      endcase
   end

endmodule

[rtl/l4b5b_gearbox.sv]
module l4b5b_gearbox (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            load,
   input  logic [l4b5b_pkg::BYTE_BITS-1:0] byte_data,
   output l4b5b_pkg::pair_type             pair
);
   import l4b5b_pkg::*;

   // From reset the held count is always even and at most 8 between bytes.
   logic [BYTE_BITS-1:0]   buffer_ff, buffer_in;
   logic [3:0]             count_ff, count_in;
   logic [BYTE_BITS-1:0]   held_mask;
   logic [2*BYTE_BITS-1:0] held;
   logic [4:0]             count_sum;

   always_comb begin
      held_mask = BYTE_BITS'((9'd1 << count_ff) - 9'd1);
      held      = {{BYTE_BITS{1'b0}}, buffer_ff & held_mask}
                | ({{BYTE_BITS{1'b0}}, byte_data} << count_ff);
      count_sum = {1'b0, count_ff} + 5'd8;

      pair.valid = (count_sum >= 5'(PAIR_BITS));
      pair.bits  = held[PAIR_BITS-1:0];

      if (pair.valid) begin
         buffer_in = {2'b00, held[2*BYTE_BITS-1:PAIR_BITS]};
         count_in  = 4'(count_sum - 5'(PAIR_BITS));
      end else begin
         buffer_in = held[BYTE_BITS-1:0];
         count_in  = 4'(count_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_ff <= '0;
         count_ff  <= '0;
      end else if (load) begin
         buffer_ff <= buffer_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/line_4b5b_byte_decoder.sv]
// Channel   Direction  Ports
// request   in         req_valid, req_stall, req_encoded_byte[7:0]
// response  out        rsp_valid, rsp_stall, rsp_decoded_byte[7:0], rsp_code_error
//
// A request is taken into an input register; then, once the response register is free or
// its byte completes no pair, the byte is appended to the gearbox and any full 10-bit pair
// is decoded into the response register. One request can enter every cycle while the response is not stalled.
// A request that completes no pair produces no response.
// Reset (synchronous) empties both registers and the gearbox bit buffer.
// A stalled response holds; requests that yield no response still drain past it.
module line_4b5b_byte_decoder (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [l4b5b_pkg::BYTE_BITS-1:0] req_encoded_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [l4b5b_pkg::BYTE_BITS-1:0] rsp_decoded_byte,
   output logic                            rsp_code_error
);
   import l4b5b_pkg::*;

   logic                 in_valid_ff, in_valid_in;
   logic [BYTE_BITS-1:0] in_byte_ff;
   logic                 out_valid_ff, out_valid_in;
   logic [BYTE_BITS-1:0] out_byte_ff;
   logic                 out_error_ff;
   logic                 out_free;
   logic                 advance;
   logic                 req_take;
   pair_type             pair;
   logic [NIB_BITS-1:0]  lo_nibble, hi_nibble;
   logic                 lo_ok, hi_ok;

   l4b5b_gearbox u_gearbox (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .byte_data (in_byte_ff),
      .pair      (pair)
   );

   l4b5b_group_decode u_lo_decode (
      .code    (pair.bits[GROUP_BITS-1:0]),
      .nibble  (lo_nibble),
      .code_ok (lo_ok)
   );

   l4b5b_group_decode u_hi_decode (
      .code    (pair.bits[PAIR_BITS-1:GROUP_BITS]),
      .nibble  (hi_nibble),
      .code_ok (hi_ok)
   );

   always_comb begin
      out_free  = !out_valid_ff || !rsp_stall;
      advance   = in_valid_ff && (out_free || !pair.valid);
      req_stall = in_valid_ff && !advance;
      req_take  = req_valid && !req_stall;

      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (advance && pair.valid) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_encoded_byte;
      end
      if (advance && pair.valid) begin
         out_byte_ff  <= {hi_nibble, lo_nibble};
         out_error_ff <= !(lo_ok && hi_ok);
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_decoded_byte = out_byte_ff;
   assign rsp_code_error   = out_error_ff;

endmodule

[dv/line_4b5b_decode_checker.sv]
module line_4b5b_decode_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_encoded_byte,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_decoded_byte,
   input  logic       rsp_code_error,
   output int         pending,
   output int         fail_count
);

   typedef struct packed {
      logic [7:0] data;
      logic       error;
   } decoded_pair_type;

   decoded_pair_type expected_bytes[$];
   logic [15:0]      held_bits;
   logic [4:0]       held_count;

   // Returns {valid, nibble} for one 5-bit line group.
   function automatic logic [4:0] group_to_nibble(input logic [4:0] grp);
      case (grp)
         5'b11110: return 5'h10;
         5'b01001: return 5'h11;
         5'b10100: return 5'h12;
         5'b10101: return 5'h13;
         5'b01010: return 5'h14;
         5'b01011: return 5'h15;
         5'b01110: return 5'h16;
         5'b01111: return 5'h17;
         5'b10010: return 5'h18;
         5'b10011: return 5'h19;
         5'b10110: return 5'h1A;
         5'b10111: return 5'h1B;
         5'b11010: return 5'h1C;
         5'b11011: return 5'h1D;
         5'b11100: return 5'h1E;
         5'b11101: return 5'h1F;
         default:  return 5'h00;
      endcase
   endfunction

   task automatic absorb_byte(input logic [7:0] line_byte);
      logic [31:0]      merged;
      int unsigned      fill;
      logic [4:0]       lo_nib;
      logic [4:0]       hi_nib;
      decoded_pair_type pair_out;
      fill = (held_count > 16) ? 16 : held_count;
      merged = ({16'd0, held_bits} & ((32'd1 << fill) - 32'd1)) | ({24'd0, line_byte} << fill);
      merged = merged & 32'h0000_FFFF;
      fill = fill + 8;
      if (fill > 16) fill = 16;
      if (fill < 10) begin
         held_bits  = merged[15:0];
         held_count = fill[4:0];
      end else begin
         held_bits  = merged[25:10];
         held_count = 5'(fill - 10);
         lo_nib = group_to_nibble(merged[4:0]);
         hi_nib = group_to_nibble(merged[9:5]);
         pair_out.data  = {hi_nib[3:0], lo_nib[3:0]};
         pair_out.error = !lo_nib[4] || !hi_nib[4];
         expected_bytes.push_back(pair_out);
      end
   endtask

   always @(posedge clock) begin : watch
      decoded_pair_type want;
      if (reset) begin
         expected_bytes.delete();
         held_bits  = '0;
         held_count = '0;
         pending    <= 0;
         fail_count <= 0;
      end else begin
         // Responses come out of registers later than their request, so pop before push.
         if (rsp_valid && !rsp_stall) begin
            if (expected_bytes.size() == 0) begin
               $display("%0t: unexpected response byte=%h error=%b", $time,
                        rsp_decoded_byte, rsp_code_error);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_bytes.pop_front();
               if (want.data !== rsp_decoded_byte || want.error !== rsp_code_error) begin
                  if (want.data !== rsp_decoded_byte)
                     $display("%0t: decoded_byte expected %h actual %h", $time,
                              want.data, rsp_decoded_byte);
                  if (want.error !== rsp_code_error)
                     $display("%0t: code_error expected %b actual %b", $time,
                              want.error, rsp_code_error);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall)
            absorb_byte(req_encoded_byte);
         pending <= expected_bytes.size();
      end
   end

endmodule

[dv/tb_line_4b5b_byte_decoder.sv]
module tb_line_4b5b_byte_decoder;

   localparam int CYCLE_LIMIT = 200000;
   localparam int CHUNKS      = 24;
   localparam int CHUNK_ITEMS = 50;

   localparam logic [4:0] DATA_CODE [16] = '{
      5'b11110, 5'b01001, 5'b10100, 5'b10101, 5'b01010, 5'b01011, 5'b01110, 5'b01111,
      5'b10010, 5'b10011, 5'b10110, 5'b10111, 5'b11010, 5'b11011, 5'b11100, 5'b11101
   };

   // Pairs of low and high groups that exercise invalid codes in each position.
   localparam logic [4:0] ODD_GROUPS [8] = '{
      5'b00000, 5'b00000, 5'b11111, 5'b11110, 5'b01001, 5'b00011, 5'b00000, 5'b10101
   };

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_stall;
   logic [l4b5b_pkg::BYTE_BITS-1:0]   req_encoded_byte;
   logic                              rsp_valid;
   logic                              rsp_stall;
   logic [l4b5b_pkg::BYTE_BITS-1:0]   rsp_decoded_byte;
   logic                              rsp_code_error;

   int          pending;
   int          fail_count;
   int          cycle_count = 0;
   logic        send_eager = 1'b0;
   logic        rsp_eager = 1'b0;
   logic [39:0] line_bits;
   int          line_fill;

   line_4b5b_byte_decoder u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_encoded_byte (req_encoded_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_decoded_byte (rsp_decoded_byte),
      .rsp_code_error   (rsp_code_error)
   );

   line_4b5b_decode_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_encoded_byte (req_encoded_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_decoded_byte (rsp_decoded_byte),
      .rsp_code_error   (rsp_code_error),
      .pending          (pending),
      .fail_count       (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_line_4b5b_byte_decoder: done, errors");
         $finish;
      end
   end

   // Called at the edge that accepted the previous request.
   task automatic send_byte(input logic [7:0] line_byte);
      int gap;
      gap = send_eager ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_encoded_byte <= line_byte;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic add_group(input logic [4:0] grp);
      line_bits = line_bits | ({35'd0, grp} << line_fill);
      line_fill = line_fill + 5;
   endtask

   task automatic send_held_bytes();
      logic [7:0] line_byte;
      while (line_fill >= 8) begin
         line_byte = line_bits[7:0];
         line_bits = line_bits >> 8;
         line_fill = line_fill - 8;
         send_byte(line_byte);
      end
   endtask

   // Five raw bytes span 40 bits, so the group alignment of the stream is kept.
   task automatic send_raw_burst(input logic [7:0] fixed, input logic use_fixed);
      repeat (5) send_byte(use_fixed ? fixed : 8'($urandom_range(0, 255)));
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      int gap;
      rsp_stall <= 1'b0;
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 29) == 0) rsp_eager = ~rsp_eager;
         gap = rsp_eager ? 0 : $urandom_range(0, 4);
         if (gap != 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_encoded_byte <= '0;
      line_bits = '0;
      line_fill = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Every data code in order, then invalid groups in low and high position.
      for (int n = 0; n < 16; n++) begin
         add_group(DATA_CODE[n]);
         send_held_bytes();
      end
      for (int n = 0; n < 8; n++) add_group(ODD_GROUPS[n]);
      send_held_bytes();
      send_raw_burst(8'h00, 1'b1);
      send_raw_burst(8'hFF, 1'b1);
      wait_for_drain();

      // Mostly valid code streams with random data, some stray groups and raw bytes.
      for (int chunk = 0; chunk < CHUNKS; chunk++) begin
         send_eager = ($urandom_range(0, 3) == 0);
         if (chunk % 8 == 7) wait_for_drain();
         for (int k = 0; k < CHUNK_ITEMS; k++) begin
            if ($urandom_range(0, 19) == 0) begin
               send_raw_burst(8'h00, 1'b0);
            end else begin
               while (line_fill < 8) begin
                  if ($urandom_range(0, 4) == 0)
                     add_group(5'($urandom_range(0, 31)));
                  else
                     add_group(DATA_CODE[$urandom_range(0, 15)]);
               end
               send_held_bytes();
            end
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("tb_line_4b5b_byte_decoder: done, clean");
      else
         $display("tb_line_4b5b_byte_decoder: done, errors");
      $finish;
   end

endmodule

[files.f]
rtl/l4b5b_pkg.sv
rtl/l4b5b_group_decode.sv
rtl/l4b5b_gearbox.sv
rtl/line_4b5b_byte_decoder.sv
dv/line_4b5b_decode_checker.sv
dv/tb_line_4b5b_byte_decoder.sv
